### rtl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants of the sample FIFO with low watermark: field
// widths, operation and status codes, register indexes and the control
// bundle passed from the pointer logic to the datapath.
// ----------------------------------------------------------------------------
package sfl_pkg;

    localparam int SLOTS_DEFAULT  = 1024;

    localparam int DATA_W         = 16;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int LEVEL_W        = 10;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 1;

    localparam int CAPACITY_RESET = 1023;
    localparam int THRESH_RESET   = 0;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PULL      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PULL_FILL = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FILLED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 1'd1;

    typedef struct packed {
        logic                we;
        logic                re;
        logic                use_fill;
        logic                low_event;
        logic [STATUS_W-1:0] status;
    } t_op_ctl;

endpackage

### rtl/sfl_in_if.sv
// ----------------------------------------------------------------------------
// sfl_in_if
// Operation channel: valid/ready handshake with the operation code, the
// sample to push and the fill sample for pull with fill.
// ----------------------------------------------------------------------------
interface sfl_in_if;
    logic                              valid;
    logic                              ready;
    logic [sfl_pkg::FUNC_W-1:0]        func;
    logic signed [sfl_pkg::DATA_W-1:0] sample_in;
    logic signed [sfl_pkg::DATA_W-1:0] fill_sample;

    modport source (output valid, output func, output sample_in, output fill_sample,
                    input ready);
    modport sink   (input valid, input func, input sample_in, input fill_sample,
                    output ready);
endinterface

### rtl/sfl_out_if.sv
// ----------------------------------------------------------------------------
// sfl_out_if
// Result channel: valid/ready handshake with the pulled sample, status,
// low-level event and fill level.
// ----------------------------------------------------------------------------
interface sfl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfl_pkg::DATA_W-1:0]   read_sample;
    logic [sfl_pkg::STATUS_W-1:0]        status;
    logic                                low_event;
    logic [sfl_pkg::LEVEL_W-1:0]         level;

    modport source (output valid, output read_sample, output status, output low_event,
                    output level, input ready);
    modport sink   (input valid, input read_sample, input status, input low_event,
                    input level, output ready);
endinterface

### rtl/sfl_ctrl.sv
// ----------------------------------------------------------------------------
// sfl_ctrl
// Ring pointer and fill level bookkeeping. Decodes each operation against
// the current level, drives the storage write/read addresses and commits
// the pointer updates when the transaction is accepted and no configuration write is taken.
// ----------------------------------------------------------------------------
module sfl_ctrl #(
    parameter int SLOTS = sfl_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [sfl_pkg::FUNC_W-1:0]     i_func,
    input  logic                           i_cfg_we,
    input  logic [sfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfl_pkg::CFG_W-1:0]      i_cfg_data,
    output sfl_pkg::t_op_ctl               o_ctl,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [AW-1:0]                  o_rd_addr,
    output logic [sfl_pkg::LEVEL_W-1:0]    o_level
);

    localparam int CAP_RESET = (sfl_pkg::CAPACITY_RESET > SLOTS - 1) ?
                               SLOTS - 1 : sfl_pkg::CAPACITY_RESET;

    logic [AW-1:0]                r_wr_ptr;
    logic [AW-1:0]                r_rd_ptr;
    logic [AW-1:0]                r_level;
    logic [AW-1:0]                r_eff_cap;
    logic [sfl_pkg::CFG_W-1:0]    r_thresh;

    logic [AW-1:0]                n_level;
    logic [AW-1:0]                n_eff_cap;
    logic [AW-1:0]                wr_next;
    logic [AW-1:0]                rd_next;
    logic [AW-1:0]                level_m1;
    logic                         empty;
    logic                         full;
    sfl_pkg::t_op_ctl             ctl;

    assign empty    = (r_level == '0);
    assign full     = (r_level == r_eff_cap);
    assign level_m1 = r_level - AW'(1);
    assign wr_next  = (r_wr_ptr == r_eff_cap) ? '0 : r_wr_ptr + AW'(1);
    assign rd_next  = (r_rd_ptr == r_eff_cap) ? '0 : r_rd_ptr + AW'(1);

    // capacity saturates at the ring size minus one
    assign n_eff_cap = (32'(i_cfg_data) > SLOTS - 1) ? AW'(SLOTS - 1) : AW'(i_cfg_data);

    always_comb begin
        ctl           = '0;
        ctl.status    = sfl_pkg::STATUS_OK;
        unique case (i_func) inside
            sfl_pkg::FUNC_PUSH: begin
                if (full) begin
                    ctl.status = sfl_pkg::STATUS_FULL;
                end else begin
                    ctl.we = 1'b1;
                end
            end
            sfl_pkg::FUNC_PULL, sfl_pkg::FUNC_PULL_FILL: begin
                if (empty) begin
                    ctl.low_event = 1'b1;
                    if (i_func == sfl_pkg::FUNC_PULL_FILL) begin
                        ctl.status   = sfl_pkg::STATUS_FILLED;
                        ctl.use_fill = 1'b1;
                    end else begin
                        ctl.status   = sfl_pkg::STATUS_EMPTY;
                    end
                end else begin
                    ctl.re        = 1'b1;
                    ctl.low_event = (32'(level_m1) < 32'(r_thresh));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_level = r_level;
        if (ctl.we) begin
            n_level = r_level + AW'(1);
        end else if (ctl.re) begin
            n_level = level_m1;
        end
    end

    assign o_ctl     = ctl;
    assign o_wr_addr = r_wr_ptr;
    assign o_rd_addr = r_rd_ptr;
    assign o_level   = sfl_pkg::LEVEL_W'(n_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_level   <= '0;
            r_eff_cap <= AW'(CAP_RESET);
            r_thresh  <= sfl_pkg::CFG_W'(sfl_pkg::THRESH_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfl_pkg::REG_CAPACITY: begin
                    // new ring size: flush
                    r_eff_cap <= n_eff_cap;
                    r_wr_ptr  <= '0;
                    r_rd_ptr  <= '0;
                    r_level   <= '0;
                end
                sfl_pkg::REG_LOW_THRESHOLD: begin
                    r_thresh  <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (ctl.we) begin
                r_wr_ptr <= wr_next;
            end
            if (ctl.re) begin
                r_rd_ptr <= rd_next;
            end
            r_level <= n_level;
        end
    end

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= r_eff_cap)
        else $error("fill level above capacity");

    a_ptrs_meet_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr == r_wr_ptr) == (r_level == '0))
        else $error("pointers disagree with fill level");

    a_push_grows_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_cfg_we && ctl.we |=> r_level == $past(r_level) + AW'(1))
        else $error("stored push did not raise the level");

endmodule

### rtl/sample_fifo_low_watermark_unit.sv
// ----------------------------------------------------------------------------
// sample_fifo_low_watermark_unit
// Circular FIFO of signed 16-bit samples with a low-level event.
// ----------------------------------------------------------------------------
// Each operation is decoded against the pointers and issues its storage
// access in the cycle it is accepted; the result is formed from the
// registered storage read and lands in the output register in the next
// cycle. No new operation is accepted while a result is being formed. The next
// operation is taken while the last result still waits in the output
// register as long as the consumer takes it in that same cycle. Storage is a
// single SLOTS-entry synchronous memory; a capacity write flushes the FIFO
// at once, with no clearing pass.
module sample_fifo_low_watermark_unit #(
    parameter int SLOTS = sfl_pkg::SLOTS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfl_in_if.sink                         i_in,
    sfl_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfl_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(SLOTS);

    logic [sfl_pkg::DATA_W-1:0]          r_mem [SLOTS];
    logic [sfl_pkg::DATA_W-1:0]          r_rd_data;

    logic                                r_busy;
    sfl_pkg::t_op_ctl                    r_s_ctl;
    logic [sfl_pkg::DATA_W-1:0]          r_s_fill;
    logic [sfl_pkg::LEVEL_W-1:0]         r_s_level;

    logic                                r_out_valid;
    logic [sfl_pkg::DATA_W-1:0]          r_out_sample;
    logic [sfl_pkg::STATUS_W-1:0]        r_out_status;
    logic                                r_out_low;
    logic [sfl_pkg::LEVEL_W-1:0]         r_out_level;

    logic                                in_ready;
    logic                                accept;
    sfl_pkg::t_op_ctl                    ctl;
    logic [AW-1:0]                       wr_addr;
    logic [AW-1:0]                       rd_addr;
    logic [sfl_pkg::LEVEL_W-1:0]         level_after;
    logic [sfl_pkg::DATA_W-1:0]          n_out_sample;

    // output register is free by the time the read data returns
    assign in_ready = !r_busy && (!r_out_valid || o_out.ready);
    assign accept   = i_in.valid && in_ready;

    assign i_in.ready = in_ready;

    sfl_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (i_in.func),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (ctl),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_level    (level_after)
    );

    always_ff @(posedge i_clk) begin
        if (accept && ctl.we) begin
            r_mem[wr_addr] <= i_in.sample_in;
        end
        if (accept && ctl.re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_out_sample = '0;
        if (r_s_ctl.re) begin
            n_out_sample = r_rd_data;
        end else if (r_s_ctl.use_fill) begin
            n_out_sample = r_s_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_ctl   <= ctl;
            r_s_fill  <= i_in.fill_sample;
            r_s_level <= level_after;
        end
        if (r_busy) begin
            r_out_sample <= n_out_sample;
            r_out_status <= r_s_ctl.status;
            r_out_low    <= r_s_ctl.low_event;
            r_out_level  <= r_s_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_sample = r_out_sample;
    assign o_out.status      = r_out_status;
    assign o_out.low_event   = r_out_low;
    assign o_out.level       = r_out_level;

endmodule
